[src/hfs_pkg.sv]
// Shared widths, constants and interface types for the heap fragmentation statistics block.
package hfs_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int SIZE_BITS   = 32;
  localparam int SUM_BITS    = 48;
  localparam int AVG_BITS    = 40;
  localparam int FRAG_BITS   = 16;
  localparam int UTIL_BITS   = 17;
  localparam int DIV_N_BITS  = 64;
  localparam int DIV_D_BITS  = 48;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
  localparam logic [SIZE_BITS-1:0]  SIZE_MAX  = '1;
  localparam logic [AVG_BITS-1:0]   AVG_MAX   = '1;
  localparam logic [UTIL_BITS-1:0]  UTIL_ONE  = UTIL_BITS'(65536);

  typedef struct packed {
    logic [COUNT_BITS-1:0] count_all;
    logic [COUNT_BITS-1:0] count_free;
    logic [COUNT_BITS-1:0] count_used;
    logic [SUM_BITS-1:0]   sum_free;
    logic [SUM_BITS-1:0]   sum_used;
    logic [SIZE_BITS-1:0]  max_free;
    logic [SIZE_BITS-1:0]  min_free;
    logic [SUM_BITS-1:0]   usage;
    logic [SUM_BITS-1:0]   arena;
  } hfs_snap_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_N_BITS-1:0] dividend;
    logic [DIV_D_BITS-1:0] divisor;
  } hfs_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_N_BITS-1:0] quotient;
  } hfs_div_rsp_t;

endpackage

[src/hfs_front.sv]
// Front end: accepts block descriptors and keeps the running walk statistics.
module hfs_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_has_block,
  input  logic                               in_block_is_free,
  input  logic [hfs_pkg::SIZE_BITS-1:0]      in_block_size,
  input  logic                               in_last_block,
  input  logic [hfs_pkg::SUM_BITS-1:0]       in_usage_bytes,
  input  logic [hfs_pkg::SUM_BITS-1:0]       in_arena_bytes,
  input  logic                               q_full,
  output logic                               q_push,
  output hfs_pkg::hfs_snap_t                 q_data
);
  import hfs_pkg::*;

  logic [COUNT_BITS-1:0] count_all_r, count_free_r, count_used_r;
  logic [COUNT_BITS-1:0] count_all_nxt, count_free_nxt, count_used_nxt;
  logic [SUM_BITS-1:0]   sum_free_r, sum_used_r, sum_free_nxt, sum_used_nxt;
  logic [SIZE_BITS-1:0]  max_free_r, min_free_r, max_free_nxt, min_free_nxt;
  logic [SUM_BITS:0]     free_add, used_add;
  logic                  blk_free, blk_used, accept;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign blk_free = in_has_block & in_block_is_free;
  assign blk_used = in_has_block & ~in_block_is_free;

  always_comb begin
    free_add = {1'b0, sum_free_r} + (SUM_BITS+1)'(in_block_size);
    used_add = {1'b0, sum_used_r} + (SUM_BITS+1)'(in_block_size);

    count_all_nxt  = (in_has_block && count_all_r != COUNT_MAX) ?
                     count_all_r + 1'b1 : count_all_r;
    count_free_nxt = (blk_free && count_free_r != COUNT_MAX) ?
                     count_free_r + 1'b1 : count_free_r;
    count_used_nxt = (blk_used && count_used_r != COUNT_MAX) ?
                     count_used_r + 1'b1 : count_used_r;

    sum_free_nxt = sum_free_r;
    if (blk_free) begin
      sum_free_nxt = free_add[SUM_BITS] ? SUM_MAX : free_add[SUM_BITS-1:0];
    end
    sum_used_nxt = sum_used_r;
    if (blk_used) begin
      sum_used_nxt = used_add[SUM_BITS] ? SUM_MAX : used_add[SUM_BITS-1:0];
    end

    max_free_nxt = (blk_free && in_block_size > max_free_r) ? in_block_size : max_free_r;
    min_free_nxt = (blk_free && in_block_size < min_free_r) ? in_block_size : min_free_r;
  end

  always_comb begin
    q_push            = accept & in_last_block;
    q_data.count_all  = count_all_nxt;
    q_data.count_free = count_free_nxt;
    q_data.count_used = count_used_nxt;
    q_data.sum_free   = sum_free_nxt;
    q_data.sum_used   = sum_used_nxt;
    q_data.max_free   = max_free_nxt;
    q_data.min_free   = min_free_nxt;
    q_data.usage      = in_usage_bytes;
    q_data.arena      = in_arena_bytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_block)) begin
      count_all_r  <= '0;
      count_free_r <= '0;
      count_used_r <= '0;
      sum_free_r   <= '0;
      sum_used_r   <= '0;
      max_free_r   <= '0;
      min_free_r   <= SIZE_MAX;
    end else if (accept) begin
      count_all_r  <= count_all_nxt;
      count_free_r <= count_free_nxt;
      count_used_r <= count_used_nxt;
      sum_free_r   <= sum_free_nxt;
      sum_used_r   <= sum_used_nxt;
      max_free_r   <= max_free_nxt;
      min_free_r   <= min_free_nxt;
    end
  end

endmodule

[src/hfs_queue.sv]
// Short queue of finished walk snapshots between the front and back ends.
module hfs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hfs_pkg::hfs_snap_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output hfs_pkg::hfs_snap_t head
);
  import hfs_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  hfs_snap_t             mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]   count_r;

  assign full  = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

[src/hfs_div.sv]
// Shared restoring divider producing one quotient bit per cycle.
module hfs_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hfs_pkg::hfs_div_req_t req,
  output hfs_pkg::hfs_div_rsp_t rsp
);
  import hfs_pkg::*;

  localparam int ITER_BITS = $clog2(DIV_N_BITS);

  logic                  busy_r, done_r;
  logic [ITER_BITS-1:0]  iter_r;
  logic [DIV_D_BITS-1:0] rem_r, dvs_r, rem_nxt;
  logic [DIV_N_BITS-1:0] quo_r;
  logic [DIV_D_BITS:0]   rem_sh;
  logic                  fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_N_BITS-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_nxt = fits ? DIV_D_BITS'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIV_D_BITS-1:0];
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + 1'b1;
        if (iter_r == ITER_BITS'(DIV_N_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_N_BITS-2:0], fits};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_r)
    else $error("divider started while busy");

endmodule

[src/hfs_back.sv]
// Back end: turns a walk snapshot into a report using the shared divider.
module hfs_back #(
  parameter int HEADER_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  hfs_pkg::hfs_snap_t              q_head,
  output hfs_pkg::hfs_div_req_t           div_req,
  input  hfs_pkg::hfs_div_rsp_t           div_rsp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hfs_pkg::COUNT_BITS-1:0]  out_block_total,
  output logic [hfs_pkg::COUNT_BITS-1:0]  out_free_total,
  output logic [hfs_pkg::COUNT_BITS-1:0]  out_used_total,
  output logic [hfs_pkg::SUM_BITS-1:0]    out_overhead_bytes,
  output logic [hfs_pkg::SIZE_BITS-1:0]   out_max_free_block,
  output logic [hfs_pkg::SIZE_BITS-1:0]   out_min_free_block,
  output logic [hfs_pkg::AVG_BITS-1:0]    out_avg_free_size,
  output logic [hfs_pkg::AVG_BITS-1:0]    out_avg_used_size,
  output logic [hfs_pkg::FRAG_BITS-1:0]   out_ext_fragmentation,
  output logic [hfs_pkg::UTIL_BITS-1:0]   out_utilization
);
  import hfs_pkg::*;

  localparam int HDR_BITS  = $clog2(HEADER_BYTES + 1);
  localparam int PROD_BITS = COUNT_BITS + HDR_BITS;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;
  typedef enum logic [1:0] {OP_AVG_FREE, OP_AVG_USED, OP_FRAG, OP_UTIL} op_t;

  state_t                state_r;
  op_t                   op_r;
  hfs_snap_t             cur_r;
  logic                  out_valid_r;
  logic [COUNT_BITS-1:0] block_total_r, free_total_r, used_total_r;
  logic [SUM_BITS-1:0]   overhead_r;
  logic [SIZE_BITS-1:0]  largest_r, smallest_r;
  logic [AVG_BITS-1:0]   avg_free_r, avg_used_r;
  logic [FRAG_BITS-1:0]  frag_r;
  logic [UTIL_BITS-1:0]  util_r;

  logic                  run;
  logic [DIV_N_BITS-1:0] dividend;
  logic [DIV_D_BITS-1:0] divisor;
  logic                  store, use_q, has_free;
  logic [AVG_BITS-1:0]   avg_res;
  logic [FRAG_BITS-1:0]  frag_res;
  logic [UTIL_BITS-1:0]  util_res;
  logic [PROD_BITS-1:0]  ovh_prod;

  always_comb begin
    unique case (op_r)
      OP_AVG_FREE: begin
        run      = cur_r.count_free != '0;
        dividend = DIV_N_BITS'({cur_r.sum_free, 8'h00});
        divisor  = DIV_D_BITS'(cur_r.count_free);
      end
      OP_AVG_USED: begin
        run      = cur_r.count_used != '0;
        dividend = DIV_N_BITS'({cur_r.sum_used, 8'h00});
        divisor  = DIV_D_BITS'(cur_r.count_used);
      end
      OP_FRAG: begin
        run      = (cur_r.count_free > COUNT_BITS'(1)) && (cur_r.sum_free != '0);
        dividend = DIV_N_BITS'({cur_r.sum_free - SUM_BITS'(cur_r.max_free), 16'h0000});
        divisor  = DIV_D_BITS'(cur_r.sum_free);
      end
      OP_UTIL: begin
        run      = cur_r.arena != '0;
        dividend = DIV_N_BITS'({cur_r.usage, 16'h0000});
        divisor  = DIV_D_BITS'(cur_r.arena);
      end
    endcase
  end

  always_comb begin
    use_q    = (state_r == S_WAIT);
    store    = ((state_r == S_ISSUE) && !run) || (use_q && div_rsp.done);
    avg_res  = '0;
    frag_res = '0;
    util_res = '0;
    if (use_q) begin
      avg_res  = (|div_rsp.quotient[DIV_N_BITS-1:AVG_BITS]) ?
                 AVG_MAX : div_rsp.quotient[AVG_BITS-1:0];
      frag_res = div_rsp.quotient[FRAG_BITS-1:0];
      util_res = (div_rsp.quotient > DIV_N_BITS'(UTIL_ONE)) ?
                 UTIL_ONE : div_rsp.quotient[UTIL_BITS-1:0];
    end
  end

  assign has_free         = q_head.count_free != '0;
  assign ovh_prod         = PROD_BITS'(q_head.count_all) * PROD_BITS'(HEADER_BYTES);
  assign q_pop            = (state_r == S_IDLE) && !q_empty;
  assign div_req.start    = (state_r == S_ISSUE) && run;
  assign div_req.dividend = dividend;
  assign div_req.divisor  = divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_AVG_FREE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cur_r         <= q_head;
            block_total_r <= q_head.count_all;
            free_total_r  <= q_head.count_free;
            used_total_r  <= q_head.count_used;
            overhead_r    <= SUM_BITS'(ovh_prod);
            largest_r     <= has_free ? q_head.max_free : '0;
            smallest_r    <= has_free ? q_head.min_free : '0;
            op_r          <= OP_AVG_FREE;
            state_r       <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (run) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
      endcase

      if (store) begin
        unique case (op_r)
          OP_AVG_FREE: avg_free_r <= avg_res;
          OP_AVG_USED: avg_used_r <= avg_res;
          OP_FRAG:     frag_r     <= frag_res;
          OP_UTIL:     util_r     <= util_res;
        endcase
        if (op_r == OP_UTIL) begin
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end else begin
          op_r    <= op_t'(op_r + 2'd1);
          state_r <= S_ISSUE;
        end
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_block_total       = block_total_r;
  assign out_free_total        = free_total_r;
  assign out_used_total        = used_total_r;
  assign out_overhead_bytes    = overhead_r;
  assign out_max_free_block    = largest_r;
  assign out_min_free_block    = smallest_r;
  assign out_avg_free_size     = avg_free_r;
  assign out_avg_used_size     = avg_used_r;
  assign out_ext_fragmentation = frag_r;
  assign out_utilization       = util_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_WAIT)
    else $error("divider finished outside a wait");
  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT)
    else $error("report shown outside the output state");

endmodule

[src/heap_fragmentation_stats_core.sv]
// Top level of the heap fragmentation statistics block.
// The input channel takes one heap block descriptor per item, one item per cycle while in_ready is high.
// Items without a block only matter when they carry last_block, which closes the walk.
// Each item marked last_block yields exactly one report item on the output channel;
// every other item yields none.
// A closed walk is copied into a two-entry queue and the running totals clear in the
// same cycle, so the next walk can start at once.
// The back end forms each report with one shared bit-serial divider and four divisions,
// a division skipped when its divisor is zero or its guard fails.
// The back end takes a walk from the queue only after the previous report has left;
// in_ready falls only while two closed walks are queued behind the one being worked on.
// If the receiver stalls, the report holds in its output register and the back end
// waits; the front end keeps taking items until the queue is full.
// Reset clears all counters and sums, empties the queue and drops out_valid.
module heap_fragmentation_stats_core #(
  parameter int HEADER_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_has_block,
  input  logic                            in_block_is_free,
  input  logic [hfs_pkg::SIZE_BITS-1:0]   in_block_size,
  input  logic                            in_last_block,
  input  logic [hfs_pkg::SUM_BITS-1:0]    in_usage_bytes,
  input  logic [hfs_pkg::SUM_BITS-1:0]    in_arena_bytes,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hfs_pkg::COUNT_BITS-1:0]  out_block_total,
  output logic [hfs_pkg::COUNT_BITS-1:0]  out_free_total,
  output logic [hfs_pkg::COUNT_BITS-1:0]  out_used_total,
  output logic [hfs_pkg::SUM_BITS-1:0]    out_overhead_bytes,
  output logic [hfs_pkg::SIZE_BITS-1:0]   out_max_free_block,
  output logic [hfs_pkg::SIZE_BITS-1:0]   out_min_free_block,
  output logic [hfs_pkg::AVG_BITS-1:0]    out_avg_free_size,
  output logic [hfs_pkg::AVG_BITS-1:0]    out_avg_used_size,
  output logic [hfs_pkg::FRAG_BITS-1:0]   out_ext_fragmentation,
  output logic [hfs_pkg::UTIL_BITS-1:0]   out_utilization
);
  import hfs_pkg::*;

  logic         q_full, q_push, q_empty, q_pop;
  hfs_snap_t    q_data, q_head;
  hfs_div_req_t div_req;
  hfs_div_rsp_t div_rsp;

  hfs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_has_block     (in_has_block),
    .in_block_is_free (in_block_is_free),
    .in_block_size    (in_block_size),
    .in_last_block    (in_last_block),
    .in_usage_bytes   (in_usage_bytes),
    .in_arena_bytes   (in_arena_bytes),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_data)
  );

  hfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  hfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hfs_back #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .q_head                (q_head),
    .div_req               (div_req),
    .div_rsp               (div_rsp),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_block_total       (out_block_total),
    .out_free_total        (out_free_total),
    .out_used_total        (out_used_total),
    .out_overhead_bytes    (out_overhead_bytes),
    .out_max_free_block    (out_max_free_block),
    .out_min_free_block    (out_min_free_block),
    .out_avg_free_size     (out_avg_free_size),
    .out_avg_used_size     (out_avg_used_size),
    .out_ext_fragmentation (out_ext_fragmentation),
    .out_utilization       (out_utilization)
  );

endmodule

[tb/heap_fragmentation_stats_core_tb.sv]
// Self-checking testbench for heap_fragmentation_stats_core driven by directed and random heap walks.
`timescale 1ns / 1ps

module heap_fragmentation_stats_core_tb;
  import hfs_pkg::*;

  localparam int HDR_BYTES    = 32;
  localparam int TABLE_ROWS   = 21;
  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_CYCLES  = 3000;
  localparam int QUIET_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 300;

  typedef struct packed {
    logic                 has_block;
    logic                 block_is_free;
    logic [SIZE_BITS-1:0] block_size;
    logic                 last_block;
    logic [SUM_BITS-1:0]  usage_bytes;
    logic [SUM_BITS-1:0]  arena_bytes;
  } walk_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] block_total;
    logic [COUNT_BITS-1:0] free_total;
    logic [COUNT_BITS-1:0] used_total;
    logic [SUM_BITS-1:0]   overhead_bytes;
    logic [SIZE_BITS-1:0]  max_free_block;
    logic [SIZE_BITS-1:0]  min_free_block;
    logic [AVG_BITS-1:0]   avg_free_size;
    logic [AVG_BITS-1:0]   avg_used_size;
    logic [FRAG_BITS-1:0]  ext_fragmentation;
    logic [UTIL_BITS-1:0]  utilization;
  } walk_report_t;

  typedef struct packed {
    walk_item_t   stim;
    logic         typed;
    walk_report_t want;
  } table_row_t;

  localparam walk_report_t ZERO_REPORT = '0;

  logic                  clk;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic                  in_has_block     = 1'b0;
  logic                  in_block_is_free = 1'b0;
  logic [SIZE_BITS-1:0]  in_block_size    = '0;
  logic                  in_last_block    = 1'b0;
  logic [SUM_BITS-1:0]   in_usage_bytes   = '0;
  logic [SUM_BITS-1:0]   in_arena_bytes   = '0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic [COUNT_BITS-1:0] out_block_total;
  logic [COUNT_BITS-1:0] out_free_total;
  logic [COUNT_BITS-1:0] out_used_total;
  logic [SUM_BITS-1:0]   out_overhead_bytes;
  logic [SIZE_BITS-1:0]  out_max_free_block;
  logic [SIZE_BITS-1:0]  out_min_free_block;
  logic [AVG_BITS-1:0]   out_avg_free_size;
  logic [AVG_BITS-1:0]   out_avg_used_size;
  logic [FRAG_BITS-1:0]  out_ext_fragmentation;
  logic [UTIL_BITS-1:0]  out_utilization;

  logic [COUNT_BITS-1:0] n_blocks   = '0;
  logic [COUNT_BITS-1:0] n_free     = '0;
  logic [COUNT_BITS-1:0] n_used     = '0;
  logic [SUM_BITS-1:0]   free_bytes = '0;
  logic [SUM_BITS-1:0]   used_bytes = '0;
  logic [SIZE_BITS-1:0]  big_free   = '0;
  logic [SIZE_BITS-1:0]  tiny_free  = SIZE_MAX;

  walk_report_t pending_reports[$];
  table_row_t   walk_table[TABLE_ROWS];

  logic steady       = 1'b0;
  logic squeeze_req  = 1'b0;
  logic squeeze_done = 1'b0;
  int   burst_left   = 0;
  int   mismatches   = 0;
  int   reports_seen = 0;
  int   items_taken  = 0;
  int   walks_closed = 0;
  int   quiet_cycles = 0;
  int   held_cycles  = 0;

  heap_fragmentation_stats_core #(
    .HEADER_BYTES(HDR_BYTES)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_has_block         (in_has_block),
    .in_block_is_free     (in_block_is_free),
    .in_block_size        (in_block_size),
    .in_last_block        (in_last_block),
    .in_usage_bytes       (in_usage_bytes),
    .in_arena_bytes       (in_arena_bytes),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_block_total      (out_block_total),
    .out_free_total       (out_free_total),
    .out_used_total       (out_used_total),
    .out_overhead_bytes   (out_overhead_bytes),
    .out_max_free_block   (out_max_free_block),
    .out_min_free_block   (out_min_free_block),
    .out_avg_free_size    (out_avg_free_size),
    .out_avg_used_size    (out_avg_used_size),
    .out_ext_fragmentation(out_ext_fragmentation),
    .out_utilization      (out_utilization)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Folds one block into the running walk totals; returns 1 with the report on a last item.
  function automatic logic tally_block(input walk_item_t it, output walk_report_t rep);
    logic [SUM_BITS:0] grown;
    logic [63:0]       num;
    logic [63:0]       den;
    rep = '0;
    if (it.has_block) begin
      if (n_blocks != COUNT_MAX) n_blocks = n_blocks + 1'b1;
      if (it.block_is_free) begin
        if (n_free != COUNT_MAX) n_free = n_free + 1'b1;
        grown = {1'b0, free_bytes} + (SUM_BITS+1)'(it.block_size);
        free_bytes = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_BITS-1:0];
        if (it.block_size > big_free) big_free = it.block_size;
        if (it.block_size < tiny_free) tiny_free = it.block_size;
      end else begin
        if (n_used != COUNT_MAX) n_used = n_used + 1'b1;
        grown = {1'b0, used_bytes} + (SUM_BITS+1)'(it.block_size);
        used_bytes = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_BITS-1:0];
      end
    end
    if (!it.last_block) return 1'b0;
    rep.block_total = n_blocks;
    rep.free_total  = n_free;
    rep.used_total  = n_used;
    num = 64'(n_blocks);
    num = num * 64'(HDR_BYTES);
    rep.overhead_bytes = (num > SUM_MAX) ? SUM_MAX : num[SUM_BITS-1:0];
    if (n_free != 0) begin
      rep.max_free_block = big_free;
      rep.min_free_block = tiny_free;
      num = 64'(free_bytes);
      den = 64'(n_free);
      num = (num << 8) / den;
      rep.avg_free_size = (num > AVG_MAX) ? AVG_MAX : num[AVG_BITS-1:0];
    end
    if (n_used != 0) begin
      num = 64'(used_bytes);
      den = 64'(n_used);
      num = (num << 8) / den;
      rep.avg_used_size = (num > AVG_MAX) ? AVG_MAX : num[AVG_BITS-1:0];
    end
    if (n_free > 1 && free_bytes != 0) begin
      num = 64'(free_bytes);
      den = 64'(free_bytes);
      num = num - 64'(big_free);
      num = (num << 16) / den;
      rep.ext_fragmentation = num[FRAG_BITS-1:0];
    end
    if (it.arena_bytes != 0) begin
      num = 64'(it.usage_bytes);
      den = 64'(it.arena_bytes);
      num = (num << 16) / den;
      rep.utilization = (num > 64'd65536) ? UTIL_ONE : num[UTIL_BITS-1:0];
    end
    n_blocks   = '0;
    n_free     = '0;
    n_used     = '0;
    free_bytes = '0;
    used_bytes = '0;
    big_free   = '0;
    tiny_free  = SIZE_MAX;
    return 1'b1;
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SIZE_MAX;
      2: return SIZE_MAX - $urandom_range(0, 15);
      3, 4: return $urandom_range(1, 4096);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SUM_BITS-1:0] pick_bytes();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SUM_MAX;
      2: return SUM_BITS'($urandom_range(1, 1 << 20));
      default: return raw[SUM_BITS-1:0];
    endcase
  endfunction

  task automatic send_item(input walk_item_t it, input logic typed, input walk_report_t want);
    walk_report_t rep;
    int           gap;
    in_valid         <= 1'b1;
    in_has_block     <= it.has_block;
    in_block_is_free <= it.block_is_free;
    in_block_size    <= it.block_size;
    in_last_block    <= it.last_block;
    in_usage_bytes   <= it.usage_bytes;
    in_arena_bytes   <= it.arena_bytes;
    do @(posedge clk); while (!in_ready);
    items_taken++;
    if (tally_block(it, rep)) begin
      pending_reports.push_back(typed ? want : rep);
      walks_closed++;
    end
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 7);
      end
    end
  endtask

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      log_mismatch($sformatf("report %0d %s got %0d want %0d", reports_seen, name, got, want));
  endtask

  task automatic check_report(input walk_report_t got);
    walk_report_t want;
    reports_seen++;
    if (pending_reports.size() == 0) begin
      log_mismatch($sformatf("report %0d arrived with none outstanding", reports_seen));
      return;
    end
    want = pending_reports.pop_front();
    cmp_field("block_total", 64'(got.block_total), 64'(want.block_total));
    cmp_field("free_total", 64'(got.free_total), 64'(want.free_total));
    cmp_field("used_total", 64'(got.used_total), 64'(want.used_total));
    cmp_field("overhead_bytes", 64'(got.overhead_bytes), 64'(want.overhead_bytes));
    cmp_field("max_free_block", 64'(got.max_free_block), 64'(want.max_free_block));
    cmp_field("min_free_block", 64'(got.min_free_block), 64'(want.min_free_block));
    cmp_field("avg_free_size", 64'(got.avg_free_size), 64'(want.avg_free_size));
    cmp_field("avg_used_size", 64'(got.avg_used_size), 64'(want.avg_used_size));
    cmp_field("ext_fragmentation", 64'(got.ext_fragmentation), 64'(want.ext_fragmentation));
    cmp_field("utilization", 64'(got.utilization), 64'(want.utilization));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_report({out_block_total, out_free_total, out_used_total, out_overhead_bytes,
                    out_max_free_block, out_min_free_block, out_avg_free_size,
                    out_avg_used_size, out_ext_fragmentation, out_utilization});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && !in_ready) held_cycles <= held_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved on either channel for %0d cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int seg_len;
    wait (rst_n);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(8, 120);
      repeat (seg_len) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= $urandom_range(0, 1);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    walk_item_t it;
    int         walk_len;
    int         free_bias;
    int         random_items;

    walk_table[0]  = {1'b0, 1'b0, 32'd0, 1'b1, 48'd0, 48'd0, 1'b1, ZERO_REPORT};
    walk_table[1]  = {1'b1, 1'b1, SIZE_MAX, 1'b1, SUM_MAX, SUM_MAX, 1'b1,
      20'd1, 20'd1, 20'd0, 48'd32, SIZE_MAX, SIZE_MAX, 40'hFF_FFFF_FF00, 40'd0, 16'd0, UTIL_ONE};
    walk_table[2]  = {1'b1, 1'b0, 32'd0, 1'b1, 48'd5, 48'd0, 1'b1,
      20'd1, 20'd0, 20'd1, 48'd32, 32'd0, 32'd0, 40'd0, 40'd0, 16'd0, 17'd0};
    walk_table[3]  = {1'b0, 1'b1, SIZE_MAX, 1'b1, SUM_MAX, 48'd1, 1'b1,
      20'd0, 20'd0, 20'd0, 48'd0, 32'd0, 32'd0, 40'd0, 40'd0, 16'd0, UTIL_ONE};
    walk_table[4]  = {1'b1, 1'b1, 32'd0, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[5]  = {1'b1, 1'b1, 32'd0, 1'b1, 48'd0, 48'd1, 1'b1,
      20'd2, 20'd2, 20'd0, 48'd64, 32'd0, 32'd0, 40'd0, 40'd0, 16'd0, 17'd0};
    walk_table[6]  = {1'b0, 1'b1, 32'd12345, 1'b0, SUM_MAX, SUM_MAX, 1'b0, ZERO_REPORT};
    walk_table[7]  = {1'b1, 1'b1, 32'd100, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[8]  = {1'b1, 1'b0, 32'd200, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[9]  = {1'b1, 1'b1, 32'd300, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[10] = {1'b0, 1'b0, 32'd0, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[11] = {1'b1, 1'b1, 32'd50, 1'b1, 48'd1000, 48'd4000, 1'b0, ZERO_REPORT};
    walk_table[12] = {1'b1, 1'b1, 32'd1, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[13] = {1'b1, 1'b1, 32'd1, 1'b1, 48'd1, 48'd3, 1'b0, ZERO_REPORT};
    walk_table[14] = {1'b1, 1'b0, SIZE_MAX, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[15] = {1'b1, 1'b0, SIZE_MAX, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[16] = {1'b1, 1'b1, 32'd7, 1'b1, SUM_MAX, SUM_MAX - 48'd1, 1'b0, ZERO_REPORT};
    walk_table[17] = {1'b1, 1'b0, 32'd0, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[18] = {1'b0, 1'b0, 32'd0, 1'b1, 48'd0, SUM_MAX, 1'b0, ZERO_REPORT};
    walk_table[19] = {1'b1, 1'b1, SIZE_MAX, 1'b0, 48'd0, 48'd0, 1'b0, ZERO_REPORT};
    walk_table[20] = {1'b1, 1'b1, 32'd0, 1'b1, 48'h8000_0000_0000, 48'h4000_0000_0000,
      1'b0, ZERO_REPORT};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < TABLE_ROWS; r++)
      send_item(walk_table[r].stim, walk_table[r].typed, walk_table[r].want);

    random_items = 0;
    steady       = 1'b1;
    squeeze_req  = 1'b1;
    repeat (12) begin
      it = {1'b1, 1'b1, pick_size(), 1'b0, pick_bytes(), pick_bytes()};
      send_item(it, 1'b0, ZERO_REPORT);
      it = {1'b1, 1'b0, pick_size(), 1'b1, pick_bytes(), pick_bytes()};
      send_item(it, 1'b0, ZERO_REPORT);
      random_items += 2;
    end
    steady = 1'b0;

    while (random_items < RANDOM_ITEMS) begin
      walk_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      free_bias = $urandom_range(0, 4);
      for (int k = 0; k < walk_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          it = {1'b0, 1'($urandom_range(0, 1)), 32'($urandom), 1'b0, pick_bytes(), pick_bytes()};
          send_item(it, 1'b0, ZERO_REPORT);
        end
        it.has_block     = (k != walk_len - 1) || ($urandom_range(0, 4) != 0);
        it.block_is_free = ($urandom_range(0, 3) < free_bias);
        it.block_size    = pick_size();
        it.last_block    = (k == walk_len - 1);
        it.usage_bytes   = pick_bytes();
        it.arena_bytes   = pick_bytes();
        if ($urandom_range(0, 5) == 0) it.usage_bytes = it.arena_bytes;
        send_item(it, 1'b0, ZERO_REPORT);
        random_items++;
      end
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d items over %0d walks, %0d reports checked, input held off %0d cycles.",
             items_taken, walks_closed, reports_seen, held_cycles);
    $display("Covered field extremes, empty and ignored items, random walks and a long hold-off.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/hfs_pkg.sv
src/hfs_front.sv
src/hfs_queue.sv
src/hfs_div.sv
src/hfs_back.sv
src/heap_fragmentation_stats_core.sv
tb/heap_fragmentation_stats_core_tb.sv
